// ===== hw/rtl/nfsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Next-fit slot pool package
// Shared widths, operation and life-state codes, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package nfsp_pkg;

  // Default pool size; the top level takes it as a parameter.
  localparam int unsigned SLOTS_DEF = 256;

  // Payload widths.
  localparam int unsigned OP_W  = 3;
  localparam int unsigned ID_W  = 8;
  localparam int unsigned CNT_W = 9;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ALLOC      = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE       = 3'd1;
  localparam logic [OP_W-1:0] OP_ACTIVATE   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEACTIVATE = 3'd3;
  localparam logic [OP_W-1:0] OP_KILL       = 3'd4;
  localparam logic [OP_W-1:0] OP_QUERY      = 3'd5;
  localparam logic [OP_W-1:0] OP_SWEEP      = 3'd6;

  // Life-state codes.
  localparam logic [1:0] LIFE_INACTIVE = 2'd0;
  localparam logic [1:0] LIFE_ALIVE    = 2'd1;
  localparam logic [1:0] LIFE_DEAD     = 2'd2;

  // The freed counter saturates here.
  localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch a new word and set up the walk
    logic clear_step;  // write one cleared entry of the slot table
    logic rd_id;       // read the entry addressed by the slot id
    logic walk;        // walk the table: next-fit search or dead sweep
    logic commit;      // apply the operation and load the result word
  } nfsp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;  // every entry has been cleared
    logic walk_end;    // search found a slot or the walk covered the pool
  } nfsp_sts_t;

endpackage

// ===== hw/rtl/nfsp_if.sv =====
// ----------------------------------------------------------------------------
// Next-fit slot pool channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface nfsp_req_if import nfsp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [ID_W-1:0] slot_id;

  modport source (output valid, operation, slot_id, input ready);
  modport sink   (input valid, operation, slot_id, output ready);
endinterface

interface nfsp_rsp_if import nfsp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  granted_slot;
  logic             pool_full;
  logic             id_valid;
  logic             slot_dead;
  logic             slot_activated;
  logic [CNT_W-1:0] freed_count;

  modport source (output valid, granted_slot, pool_full, id_valid, slot_dead,
                  slot_activated, freed_count, input ready);
  modport sink   (input valid, granted_slot, pool_full, id_valid, slot_dead,
                  slot_activated, freed_count, output ready);
endinterface

// ===== hw/rtl/nfsp_dp.sv =====
// ----------------------------------------------------------------------------
// Next-fit slot pool datapath
// Slot table memory, next-fit pointer, walk counters and the result register.
// ----------------------------------------------------------------------------
module nfsp_dp import nfsp_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nfsp_cmd_t        cmd_i,
  output nfsp_sts_t        sts_o,
  input  logic [OP_W-1:0]  op_i,
  input  logic [ID_W-1:0]  id_i,
  output logic [ID_W-1:0]  granted_slot_o,
  output logic             pool_full_o,
  output logic             id_valid_o,
  output logic             slot_dead_o,
  output logic             slot_activated_o,
  output logic [CNT_W-1:0] freed_count_o
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned IW = (AW > ID_W) ? AW : ID_W;
  localparam logic [AW:0]   SlotsCnt = (AW + 1)'(SLOTS);
  localparam logic [AW-1:0] LastAddr = AW'(SLOTS - 1);
  localparam logic [IW:0]   SlotsId  = (IW + 1)'(SLOTS);

  typedef struct packed {
    logic       used;
    logic [1:0] life;
  } entry_t;

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    return (a == LastAddr) ? '0 : a + AW'(1);
  endfunction

  entry_t mem [SLOTS];

  logic [OP_W-1:0]  op_q;
  logic [ID_W-1:0]  id_q;
  logic [AW-1:0]    ptr_q;
  logic [AW-1:0]    walk_addr_q;
  logic [AW:0]      cnt_q;
  logic [AW-1:0]    chk_addr_q;
  logic             chk_vld_q;
  entry_t           rd_data_q;
  logic [CNT_W-1:0] freed_q;

  logic [ID_W-1:0]  granted_q, granted_d;
  logic             full_q, full_d;
  logic             valid_q, valid_d;
  logic             dead_q, dead_d;
  logic             act_q, act_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic [IW-1:0] id_w;
  logic [IW-1:0] chk_w;
  logic [AW-1:0] id_addr;
  logic          id_ok;
  logic          is_alloc;
  logic          found;
  logic          cnt_full;
  logic          walk_done;
  logic          walk_rd;
  logic          clear_wr;
  logic          sweep_hit;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  assign id_w      = IW'(id_q);
  assign chk_w     = IW'(chk_addr_q);
  assign id_addr   = id_w[AW-1:0];
  assign id_ok     = ({1'b0, id_w} < SlotsId) && rd_data_q.used;
  assign is_alloc  = (op_q == OP_ALLOC);
  assign found     = chk_vld_q && !rd_data_q.used;
  assign cnt_full  = (cnt_q == SlotsCnt);
  assign walk_done = cnt_full && !chk_vld_q;

  // Reads stream one address a cycle; the search stops issuing once it has a hit.
  assign walk_rd   = cmd_i.walk && !cnt_full && !(is_alloc && found);
  assign clear_wr  = cmd_i.clear_step && !cnt_full;
  assign sweep_hit = cmd_i.walk && !is_alloc && chk_vld_q && rd_data_q.used &&
                     (rd_data_q.life == LIFE_DEAD);

  assign rd_en   = cmd_i.rd_id || walk_rd;
  assign rd_addr = cmd_i.rd_id ? id_addr : walk_addr_q;

  assign sts_o.clear_done = cnt_full;
  assign sts_o.walk_end   = is_alloc ? (found || walk_done) : walk_done;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = walk_addr_q;
    wr_data = '0;
    if (clear_wr) begin
      wr_en = 1'b1;
    end else if (sweep_hit) begin
      wr_en   = 1'b1;
      wr_addr = chk_addr_q;
      wr_data = '{used: 1'b0, life: rd_data_q.life};
    end else if (cmd_i.commit) begin
      wr_addr = id_addr;
      case (op_q)
        OP_ALLOC: begin
          wr_en   = found;
          wr_addr = chk_addr_q;
          wr_data = '{used: 1'b1, life: LIFE_INACTIVE};
        end
        OP_FREE: begin
          wr_en   = id_ok;
          wr_data = '{used: 1'b0, life: rd_data_q.life};
        end
        OP_ACTIVATE: begin
          wr_en   = id_ok;
          wr_data = '{used: 1'b1, life: LIFE_ALIVE};
        end
        OP_DEACTIVATE: begin
          wr_en   = id_ok;
          wr_data = '{used: 1'b1, life: LIFE_INACTIVE};
        end
        OP_KILL: begin
          wr_en   = id_ok;
          wr_data = '{used: 1'b1, life: LIFE_DEAD};
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    granted_d = '0;
    full_d    = 1'b0;
    valid_d   = 1'b0;
    dead_d    = 1'b0;
    act_d     = 1'b0;
    count_d   = '0;
    case (op_q)
      OP_ALLOC: begin
        if (found) begin
          granted_d = chk_w[ID_W-1:0];
        end else begin
          full_d = 1'b1;
        end
      end
      OP_FREE, OP_ACTIVATE, OP_DEACTIVATE, OP_KILL: begin
        valid_d = id_ok;
      end
      OP_QUERY: begin
        valid_d = id_ok;
        dead_d  = id_ok ? (rd_data_q.life == LIFE_DEAD) : 1'b1;
        act_d   = id_ok && (rd_data_q.life != LIFE_INACTIVE);
      end
      OP_SWEEP: begin
        count_d = freed_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      walk_addr_q <= '0;
      cnt_q       <= '0;
      chk_vld_q   <= 1'b0;
      freed_q     <= '0;
    end else begin
      // A found slot stays flagged while the update waits for the output.
      if (cmd_i.commit) begin
        chk_vld_q <= 1'b0;
      end else if (cmd_i.walk) begin
        chk_vld_q <= walk_rd;
      end
      if (cmd_i.capture) begin
        walk_addr_q <= (op_i == OP_SWEEP) ? '0 : ptr_q;
        cnt_q       <= '0;
        freed_q     <= '0;
      end else if (clear_wr || walk_rd) begin
        walk_addr_q <= addr_inc(walk_addr_q);
        cnt_q       <= cnt_q + (AW + 1)'(1);
      end
      if (sweep_hit && (freed_q != COUNT_MAX)) begin
        freed_q <= freed_q + CNT_W'(1);
      end
      if (cmd_i.commit && is_alloc && found) begin
        ptr_q <= addr_inc(chk_addr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= op_i;
      id_q <= id_i;
    end
    if (walk_rd) begin
      chk_addr_q <= walk_addr_q;
    end
    if (cmd_i.commit) begin
      granted_q <= granted_d;
      full_q    <= full_d;
      valid_q   <= valid_d;
      dead_q    <= dead_d;
      act_q     <= act_d;
      count_q   <= count_d;
    end
  end

  // Slot table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign granted_slot_o   = granted_q;
  assign pool_full_o      = full_q;
  assign id_valid_o       = valid_q;
  assign slot_dead_o      = dead_q;
  assign slot_activated_o = act_q;
  assign freed_count_o    = count_q;

endmodule

// ===== hw/rtl/nfsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Next-fit slot pool controller
// Sequences table clearing, request words, walks and the response handshake.
// ----------------------------------------------------------------------------
module nfsp_ctrl import nfsp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic [OP_W-1:0] req_op_i,
  output logic            req_ready_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  input  nfsp_sts_t       sts_i,
  output nfsp_cmd_t       cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       out_free;
  logic       accept;

  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          case (req_op_i) inside
            OP_ALLOC, OP_SWEEP: state_d = ST_WALK;
            OP_FREE, OP_ACTIVATE, OP_DEACTIVATE, OP_KILL, OP_QUERY:
              state_d = ST_READ;
            default: state_d = ST_EXEC;
          endcase
        end
      end
      ST_READ: begin
        cmd_o.rd_id = 1'b1;
        state_d     = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (!sts_i.walk_end) begin
          cmd_o.walk = 1'b1;
        end else if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.commit) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

// ===== hw/rtl/next_fit_slot_pool_top.sv =====
// Free, activate, deactivate, kill and query read the table entry of their id,
// then update it and load the response word into the output register.
// Allocate walks the table from the next-fit pointer until it meets a free
// slot or has covered the whole pool; sweep walks every entry of the pool.
// Words run one at a time, walking one table entry a cycle.
// After reset a clearing pass over every entry runs before the first word.
// ----------------------------------------------------------------------------
// Next-fit slot pool
// A fixed pool of slots, each with a used bit and a life state, handed out by
// a next-fit search from a rotating pointer.
// ----------------------------------------------------------------------------
module next_fit_slot_pool_top import nfsp_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nfsp_req_if.sink   req_i,
  nfsp_rsp_if.source rsp_o
);

  // The controller owns the handshakes and the sequencing; the datapath owns
  // the slot table, the pointer, the walk counters and the response payload.
  // A request word is taken only in the idle state, but a finished response
  // may still be waiting in the output register at that time: the next word
  // then runs up to its update and waits there for the register to drain.

  nfsp_cmd_t cmd;
  nfsp_sts_t sts;

  nfsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.operation),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The table holds a used bit and a life state per slot. Reset clears the
  // used bits through the clearing pass; life states are written whenever a
  // slot is handed out, so a slot's life state is never read before it is set.
  nfsp_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (req_i.operation),
    .id_i             (req_i.slot_id),
    .granted_slot_o   (rsp_o.granted_slot),
    .pool_full_o      (rsp_o.pool_full),
    .id_valid_o       (rsp_o.id_valid),
    .slot_dead_o      (rsp_o.slot_dead),
    .slot_activated_o (rsp_o.slot_activated),
    .freed_count_o    (rsp_o.freed_count)
  );

endmodule

// ===== bench/next_fit_slot_pool_top_test.sv =====
// ----------------------------------------------------------------------------
// Next-fit slot pool testbench
// Drives request words through the valid/ready channel and keeps a slot-table
// model that predicts each response word. The model covers allocation, free,
// life-state changes, query and the dead sweep. The bench checks every
// response word in order, with random idling and back-pressure.
// ----------------------------------------------------------------------------
module next_fit_slot_pool_top_test;
  import nfsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Pool size of the block under test: the top level keeps its default.
  localparam int unsigned POOL = SLOTS_DEF;

  // The one operation code that the package leaves unnamed. The block must
  // treat it as a no-op that still returns an all-zero response word.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  // Worst case is near 620 words, each as slow as a sweep plus the longest
  // sender gap and receiver stall. Allow a wide margin.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_REPORTS = 10;

  // One response word, laid out in the order of the response channel.
  typedef struct packed {
    logic [ID_W-1:0]  granted_slot;
    logic             pool_full;
    logic             id_valid;
    logic             slot_dead;
    logic             slot_activated;
    logic [CNT_W-1:0] freed_count;
  } pool_rsp_t;

  logic clk_i;
  logic rst_ni;

  nfsp_req_if req ();
  nfsp_rsp_if rsp ();

  next_fit_slot_pool_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  // The bench keeps its own copy of the slot table. A slot's life state is
  // only read while the slot is in use, so it never needs a reset value.
  bit          slot_used [POOL];
  logic [1:0]  slot_life [POOL];
  int unsigned alloc_ptr;

  // Response words still owed by the block, oldest first.
  pool_rsp_t   expected_rsp [$];

  int unsigned fail_count;
  int unsigned cycle_count;

  // These switch the random idling on each side.
  bit          req_gaps_on;
  bit          rsp_stall_on;
  int unsigned ready_hold;

  // The clock has a 4 ns period.
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // The run stops here if the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // An idle stretch is usually zero, sometimes a few cycles and now and then
  // long, so that gaps land on every phase of a table walk.
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Applies one request word to the slot table and returns the response word
  // that it must produce.
  function automatic pool_rsp_t pool_predict(input logic [OP_W-1:0] op,
                                             input logic [ID_W-1:0] id);
    pool_rsp_t   res;
    int unsigned idx;
    int unsigned start;
    int unsigned probe;
    bit          found;
    bit          in_use;

    res    = '0;
    idx    = 32'(id);
    in_use = (idx < POOL) && slot_used[idx];
    case (op)
      OP_ALLOC: begin
        // Next-fit: scan from the pointer, wrapping once.
        start = alloc_ptr % POOL;
        probe = start;
        found = 1'b1;
        while (slot_used[probe]) begin
          probe = (probe + 1) % POOL;
          if (probe == start) begin
            found = 1'b0;
            break;
          end
        end
        if (found) begin
          slot_used[probe] = 1'b1;
          slot_life[probe] = LIFE_INACTIVE;
          alloc_ptr        = (probe + 1) % POOL;
          res.granted_slot = probe[ID_W-1:0];
        end else begin
          res.pool_full = 1'b1;
        end
      end
      OP_FREE: begin
        res.id_valid = in_use;
        if (in_use) slot_used[idx] = 1'b0;
      end
      OP_ACTIVATE: begin
        res.id_valid = in_use;
        if (in_use) slot_life[idx] = LIFE_ALIVE;
      end
      OP_DEACTIVATE: begin
        res.id_valid = in_use;
        if (in_use) slot_life[idx] = LIFE_INACTIVE;
      end
      OP_KILL: begin
        res.id_valid = in_use;
        if (in_use) slot_life[idx] = LIFE_DEAD;
      end
      OP_QUERY: begin
        // An unusable id reads as dead and not activated.
        res.id_valid = in_use;
        if (in_use) begin
          res.slot_dead      = (slot_life[idx] == LIFE_DEAD);
          res.slot_activated = (slot_life[idx] != LIFE_INACTIVE);
        end else begin
          res.slot_dead = 1'b1;
        end
      end
      OP_SWEEP: begin
        for (int unsigned s = 0; s < POOL; s++) begin
          if (slot_used[s] && slot_life[s] == LIFE_DEAD) begin
            slot_used[s] = 1'b0;
            if (res.freed_count != COUNT_MAX) res.freed_count++;
          end
        end
      end
      default: begin
        // The unused code changes nothing.
      end
    endcase
    return res;
  endfunction

  // Returns a slot that is in use, starting from a random place. With an
  // empty pool it falls back to any id.
  function automatic logic [ID_W-1:0] pick_used_slot();
    int unsigned start;
    int unsigned probe;
    start = $urandom_range(0, POOL - 1);
    for (int unsigned k = 0; k < POOL; k++) begin
      probe = (start + k) % POOL;
      if (slot_used[probe]) return probe[ID_W-1:0];
    end
    return ID_W'($urandom_range(0, (1 << ID_W) - 1));
  endfunction

  function automatic string rsp_text(input pool_rsp_t r);
    return $sformatf("granted=%0d full=%0b valid=%0b dead=%0b act=%0b freed=%0d",
                     r.granted_slot, r.pool_full, r.id_valid, r.slot_dead,
                     r.slot_activated, r.freed_count);
  endfunction

  task automatic report_fail(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Sends one request word. Every call starts and ends at a falling edge.
  // When no gap is wanted, valid simply stays high for the next word, so it
  // is never lowered and raised again in the same time step. The expected
  // response is worked out at the edge where the word is taken.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
    int unsigned gap;
    gap = req_gaps_on ? idle_len() : 0;
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.slot_id   <= id;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    expected_rsp.push_back(pool_predict(op, id));
    @(negedge clk_i);
  endtask

  // The receiver holds ready for random stretches while stalls are on.
  initial begin
    rsp.ready  = 1'b0;
    ready_hold = 0;
    forever begin
      @(negedge clk_i);
      if (!rsp_stall_on) begin
        rsp.ready <= 1'b1;
      end else if (ready_hold != 0) begin
        ready_hold--;
      end else begin
        rsp.ready  <= ($urandom_range(0, 2) != 0);
        ready_hold = idle_len();
      end
    end
  end

  // Every response word taken by the receiver is compared with the oldest
  // expectation. The request side may push a newer word in the same step;
  // it goes to the back, so the oldest expectation is already in place.
  always @(posedge clk_i) begin : rsp_check
    pool_rsp_t seen;
    pool_rsp_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      seen.granted_slot   = rsp.granted_slot;
      seen.pool_full      = rsp.pool_full;
      seen.id_valid       = rsp.id_valid;
      seen.slot_dead      = rsp.slot_dead;
      seen.slot_activated = rsp.slot_activated;
      seen.freed_count    = rsp.freed_count;
      if (expected_rsp.size() == 0) begin
        report_fail({"response word with none expected: ", rsp_text(seen)});
      end else begin
        want = expected_rsp.pop_front();
        if (seen !== want) begin
          report_fail({"expected ", rsp_text(want), " got ", rsp_text(seen)});
        end
      end
    end
  end

  // Short directed sequence: unused ids on every slot operation, the unused
  // code, a first allocation, each life-state change, a query of each state,
  // a sweep, and next-fit skipping a slot freed behind the pointer.
  task automatic test_directed();
    req_gaps_on  = 1'b0;
    rsp_stall_on = 1'b0;
    send_word(OP_QUERY, 8'd0);
    send_word(OP_FREE, 8'd255);
    send_word(OP_ACTIVATE, 8'd128);
    send_word(OP_DEACTIVATE, 8'd1);
    send_word(OP_KILL, 8'd254);
    send_word(OP_UNUSED, 8'hAA);
    send_word(OP_SWEEP, 8'h55);
    send_word(OP_ALLOC, 8'hFF);
    send_word(OP_ALLOC, 8'h00);
    send_word(OP_ALLOC, 8'h00);
    send_word(OP_QUERY, 8'd0);
    send_word(OP_ACTIVATE, 8'd1);
    send_word(OP_QUERY, 8'd1);
    send_word(OP_KILL, 8'd2);
    send_word(OP_QUERY, 8'd2);
    send_word(OP_DEACTIVATE, 8'd1);
    send_word(OP_QUERY, 8'd1);
    send_word(OP_SWEEP, 8'h00);
    send_word(OP_QUERY, 8'd2);
    send_word(OP_FREE, 8'd0);
    send_word(OP_ALLOC, 8'h00);
    send_word(OP_FREE, 8'd1);
    send_word(OP_QUERY, 8'd1);
    send_word(OP_SWEEP, 8'h00);
  endtask

  // Fills the pool so the next-fit pointer wraps past a used slot and the
  // last allocation reports full. Then every slot is killed and a single
  // sweep frees the whole pool, which uses the top bit of the freed count.
  task automatic test_pool_full();
    req_gaps_on  = 1'b0;
    rsp_stall_on = 1'b0;
    for (int unsigned n = 0; n <= POOL; n++) send_word(OP_ALLOC, 8'h00);
    send_word(OP_ALLOC, 8'hFF);
    req_gaps_on  = 1'b1;
    rsp_stall_on = 1'b1;
    for (int unsigned s = 0; s < POOL; s++) send_word(OP_KILL, s[ID_W-1:0]);
    send_word(OP_QUERY, 8'd255);
    send_word(OP_SWEEP, 8'h00);
    send_word(OP_QUERY, 8'd255);
  endtask

  // Random traffic. Most slot operations address a slot in use, so that
  // allocate, activate, kill, query and sweep chains go deep. The rest use
  // any id, which also exercises the unused-id path.
  task automatic test_random_traffic(input int unsigned words, input bit gaps,
                                     input bit stalls);
    int unsigned      pick;
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    req_gaps_on  = gaps;
    rsp_stall_on = stalls;
    repeat (words) begin
      pick = $urandom_range(0, 99);
      if (pick < 28)      op = OP_ALLOC;
      else if (pick < 38) op = OP_FREE;
      else if (pick < 52) op = OP_ACTIVATE;
      else if (pick < 62) op = OP_DEACTIVATE;
      else if (pick < 76) op = OP_KILL;
      else if (pick < 95) op = OP_QUERY;
      else if (pick < 98) op = OP_SWEEP;
      else                op = OP_UNUSED;
      if (op != OP_ALLOC && op != OP_SWEEP && $urandom_range(0, 3) != 0) begin
        id = pick_used_slot();
      end else begin
        id = ID_W'($urandom_range(0, (1 << ID_W) - 1));
      end
      send_word(op, id);
    end
  endtask

  // After the last request word, wait for every owed response, then for
  // about one table walk more so that any extra word would show up.
  task automatic drain_responses();
    req.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (POOL + 8) @(posedge clk_i);
    if (expected_rsp.size() != 0) report_fail("response words missing at the end");
  endtask

  initial begin
    fail_count    = 0;
    cycle_count   = 0;
    alloc_ptr     = 0;
    req_gaps_on   = 1'b0;
    rsp_stall_on  = 1'b0;
    foreach (slot_used[s]) slot_used[s] = 1'b0;
    foreach (slot_life[s]) slot_life[s] = LIFE_INACTIVE;
    rst_ni        = 1'b0;
    req.valid     = 1'b0;
    req.operation = OP_ALLOC;
    req.slot_id   = '0;

    // Hold reset, then release it at a falling edge. The block then runs its
    // clearing pass, and the first word simply waits on ready.
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_pool_full();
    test_random_traffic(20, 1'b0, 1'b0);
    test_random_traffic(40, 1'b1, 1'b1);
    test_random_traffic(20, 1'b1, 1'b0);
    drain_responses();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== next_fit_slot_pool_top.f =====
hw/rtl/nfsp_pkg.sv
hw/rtl/nfsp_if.sv
hw/rtl/nfsp_dp.sv
hw/rtl/nfsp_ctrl.sv
hw/rtl/next_fit_slot_pool_top.sv
bench/next_fit_slot_pool_top_test.sv
